// File: rtl/vpad_pkg.sv
`timescale 1ns / 1ps
// vpad_pkg: shared types, widths and the arctangent table of the polar angle pipeline
// no dependencies; imported by every module of the block

package vpad_pkg;

    localparam int COORD_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int ZFRAC     = 24;
    localparam int PRE_SHIFT = 59 - COORD_W;
    localparam int XY_W      = 62;
    localparam int Z_W       = 33;
    localparam int PHI_W     = 31;
    localparam int TOT_W     = 33;
    localparam int ATAN_W    = 31;
    localparam int MAX_STEPS = 32;
    localparam int IDX_W     = $clog2(MAX_STEPS);

    localparam logic [TOT_W-1:0] DEG90_Q24  = TOT_W'(90) << ZFRAC;
    localparam logic [TOT_W-1:0] DEG180_Q24 = TOT_W'(180) << ZFRAC;
    localparam logic [TOT_W-1:0] DEG360_Q24 = TOT_W'(360) << ZFRAC;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } vpad_in_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_deg;
        logic               at_origin;
    } vpad_out_t;

    typedef struct packed {
        logic at_origin;
        logic x_zero;
        logic y_zero;
        logic x_neg;
        logic y_neg;
    } vpad_quad_t;

    typedef struct packed {
        vpad_quad_t             quad;
        logic signed [XY_W-1:0] px;
        logic signed [XY_W-1:0] py;
        logic signed [Z_W-1:0]  z;
    } vpad_rot_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 31'd754974720;
            5'd1:    v = 31'd445687602;
            5'd2:    v = 31'd235489088;
            5'd3:    v = 31'd119537938;
            5'd4:    v = 31'd60000934;
            5'd5:    v = 31'd30029717;
            5'd6:    v = 31'd15018523;
            5'd7:    v = 31'd7509720;
            5'd8:    v = 31'd3754917;
            5'd9:    v = 31'd1877466;
            5'd10:   v = 31'd938734;
            5'd11:   v = 31'd469367;
            5'd12:   v = 31'd234684;
            5'd13:   v = 31'd117342;
            5'd14:   v = 31'd58671;
            5'd15:   v = 31'd29335;
            5'd16:   v = 31'd14668;
            5'd17:   v = 31'd7334;
            5'd18:   v = 31'd3667;
            5'd19:   v = 31'd1833;
            5'd20:   v = 31'd917;
            5'd21:   v = 31'd458;
            5'd22:   v = 31'd229;
            5'd23:   v = 31'd115;
            5'd24:   v = 31'd57;
            5'd25:   v = 31'd29;
            5'd26:   v = 31'd14;
            5'd27:   v = 31'd7;
            5'd28:   v = 31'd4;
            5'd29:   v = 31'd2;
            5'd30:   v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/vector_polar_angle_degrees.sv
`timescale 1ns / 1ps
// vector_polar_angle_degrees: polar angle of a signed vector in degrees, cordic vectoring
// pipeline stages: input stage, one stage per
// micro-rotation, clamp/quadrant stage and rounding/output stage
// throughput one transfer per cycle; every stage holds its item while the next is full
// aresetn synchronous active low, clears all valid bits; no other state
// depends on vpad_pkg, vpad_prep, vpad_stage, vpad_finish

module vector_polar_angle_degrees #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vpad_pkg::vpad_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vpad_pkg::vpad_out_t m_data
);
    import vpad_pkg::*;

    localparam bit FITS = (9 + ANGLE_FRAC_BITS) <= ANGLE_W;
    localparam logic [ANGLE_W:0] LIMIT = (ANGLE_W + 1)'(360) << ANGLE_FRAC_BITS;

    vpad_rot_t pipe_data  [CORDIC_STEPS+1];
    logic      pipe_valid [CORDIC_STEPS+1];
    logic      pipe_ready [CORDIC_STEPS+1];

    vpad_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (pipe_valid[0]),
        .out_ready (pipe_ready[0]),
        .out_data  (pipe_data[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        vpad_stage #(
            .STEP_IDX (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pipe_valid[i]),
            .in_ready  (pipe_ready[i]),
            .in_data   (pipe_data[i]),
            .out_valid (pipe_valid[i+1]),
            .out_ready (pipe_ready[i+1]),
            .out_data  (pipe_data[i+1])
        );
    end

    vpad_finish #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pipe_valid[CORDIC_STEPS]),
        .in_ready  (pipe_ready[CORDIC_STEPS]),
        .in_data   (pipe_data[CORDIC_STEPS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    a_origin_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.at_origin |-> m_data.angle_deg == '0)
        else $error("origin result with nonzero angle");

    a_angle_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && FITS |-> {1'b0, m_data.angle_deg} < LIMIT)
        else $error("angle not below 360 degrees");

    a_stall_only_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while output side free");

endmodule

// File: rtl/vpad_prep.sv
`timescale 1ns / 1ps
// vpad_prep: input register stage, folds the vector into the first quadrant
// depends on vpad_pkg

module vpad_prep (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  vpad_pkg::vpad_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vpad_pkg::vpad_rot_t out_data
);
    import vpad_pkg::*;

    logic                   valid_reg;
    vpad_rot_t              data_reg;
    vpad_rot_t              data_next;
    logic signed [COORD_W:0] x_ext;
    logic signed [COORD_W:0] y_ext;
    logic signed [COORD_W:0] x_abs;
    logic signed [COORD_W:0] y_abs;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        x_ext = {in_data.x_coord[COORD_W-1], in_data.x_coord};
        y_ext = {in_data.y_coord[COORD_W-1], in_data.y_coord};
        x_abs = x_ext[COORD_W] ? -x_ext : x_ext;
        y_abs = y_ext[COORD_W] ? -y_ext : y_ext;

        data_next.quad.x_zero    = (in_data.x_coord == '0);
        data_next.quad.y_zero    = (in_data.y_coord == '0);
        data_next.quad.at_origin = data_next.quad.x_zero && data_next.quad.y_zero;
        data_next.quad.x_neg     = in_data.x_coord[COORD_W-1];
        data_next.quad.y_neg     = in_data.y_coord[COORD_W-1];
        data_next.px = {{(XY_W-COORD_W-1){1'b0}}, x_abs} <<< PRE_SHIFT;
        data_next.py = {{(XY_W-COORD_W-1){1'b0}}, y_abs} <<< PRE_SHIFT;
        data_next.z  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/vpad_stage.sv
`timescale 1ns / 1ps
// vpad_stage: one registered cordic vectoring micro-rotation
// depends on vpad_pkg

module vpad_stage #(
    parameter int STEP_IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  vpad_pkg::vpad_rot_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vpad_pkg::vpad_rot_t out_data
);
    import vpad_pkg::*;

    localparam logic [IDX_W-1:0] IDX = IDX_W'(STEP_IDX);

    logic                   valid_reg;
    vpad_rot_t              data_reg;
    vpad_rot_t              data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  step_z;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        dx     = in_data.py >>> STEP_IDX;
        dy     = in_data.px >>> STEP_IDX;
        step_z = Z_W'(atan_deg(IDX));
        data_next      = in_data;
        if (!in_data.py[XY_W-1]) begin
            data_next.px = in_data.px + dx;
            data_next.py = in_data.py - dy;
            data_next.z  = in_data.z + step_z;
        end else begin
            data_next.px = in_data.px - dx;
            data_next.py = in_data.py + dy;
            data_next.z  = in_data.z - step_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/vpad_finish.sv
`timescale 1ns / 1ps
// vpad_finish: clamp and quadrant placement, then rounding, wrap and special cases
// two register stages, the second is the output register; depends on vpad_pkg

module vpad_finish #(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  vpad_pkg::vpad_rot_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vpad_pkg::vpad_out_t out_data
);
    import vpad_pkg::*;

    localparam int SH    = ZFRAC - ANGLE_FRAC_BITS;
    localparam int ANG_W = TOT_W - SH;
    localparam logic [TOT_W-1:0] HALF   = TOT_W'(1) << (SH - 1);
    localparam logic [ANG_W-1:0] FULL   = ANG_W'(360) << ANGLE_FRAC_BITS;
    localparam logic [ANG_W-1:0] ANG90  = ANG_W'(90) << ANGLE_FRAC_BITS;
    localparam logic [ANG_W-1:0] ANG270 = ANG_W'(270) << ANGLE_FRAC_BITS;

    logic              valid_a_reg;
    logic              ready_a;
    logic [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]  total_next;
    vpad_quad_t        quad_reg;
    logic [PHI_W-1:0]  phi;
    logic              valid_b_reg;
    logic              ready_b;
    vpad_out_t         out_reg;
    vpad_out_t         out_next;
    logic [TOT_W-1:0]  rounded;
    logic [ANG_W-1:0]  ang;

    // stage a: clamp phi to [0, 90] and place it by quadrant
    always_comb begin
        if (in_data.z[Z_W-1] || in_data.quad.y_zero) begin
            phi = '0;
        end else if (TOT_W'(in_data.z) > DEG90_Q24) begin
            phi = PHI_W'(DEG90_Q24);
        end else begin
            phi = PHI_W'(in_data.z);
        end
        case ({in_data.quad.x_neg, in_data.quad.y_neg})
            2'b00:   total_next = TOT_W'(phi);
            2'b01:   total_next = DEG360_Q24 - TOT_W'(phi);
            2'b10:   total_next = DEG180_Q24 - TOT_W'(phi);
            default: total_next = DEG180_Q24 + TOT_W'(phi);
        endcase
    end

    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
        end else if (ready_a) begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && in_valid) begin
            total_reg <= total_next;
            quad_reg  <= in_data.quad;
        end
    end

    // stage b: round half up, wrap 360 to 0, exact axes and origin
    always_comb begin
        rounded = (total_reg + HALF) >> SH;
        ang     = rounded[ANG_W-1:0];
        if (ang >= FULL) begin
            ang = ang - FULL;
        end
        out_next.at_origin = 1'b0;
        if (quad_reg.at_origin) begin
            out_next.angle_deg = '0;
            out_next.at_origin = 1'b1;
        end else if (quad_reg.x_zero) begin
            out_next.angle_deg = ANGLE_W'(quad_reg.y_neg ? ANG270 : ANG90);
        end else begin
            out_next.angle_deg = ANGLE_W'(ang);
        end
    end

    assign ready_b   = !valid_b_reg || out_ready;
    assign out_valid = valid_b_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
        end else if (ready_b) begin
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_b && valid_a_reg) begin
            out_reg <= out_next;
        end
    end

endmodule
